// ===== rtl/core/sbda_pkg.sv =====
package sbda_pkg;

  localparam int VALUE_W       = 32;
  localparam int DIGITS        = 10;
  localparam int POS_W         = 4;
  localparam int CHAR_W        = 8;
  localparam int DABBLE_STAGES = 4;
  localparam int STAGE_STEPS   = VALUE_W / DABBLE_STAGES;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  // Work word of the shift-and-add-3 conversion
  typedef struct packed {
    logic                        neg;
    logic [VALUE_W-1:0]          bin;
    logic [DIGITS-1:0][3:0]      bcd;
  } dabble_t;

  // One double dabble step: correct digits of 5 or more, then shift left
  function automatic dabble_t dabble_step(input dabble_t d);
    dabble_t r;
    r = d;
    for (int i = 0; i < DIGITS; i++) begin
      if (r.bcd[i] >= 4'd5) begin
        r.bcd[i] = r.bcd[i] + 4'd3;
      end
    end
    {r.bcd, r.bin} = {r.bcd, r.bin} << 1;
    return r;
  endfunction

  // The steps that one pipeline stage performs
  function automatic dabble_t dabble_stage(input dabble_t d);
    dabble_t r;
    r = d;
    for (int s = 0; s < STAGE_STEPS; s++) begin
      r = dabble_step(r);
    end
    return r;
  endfunction

  // Index of the most significant nonzero digit, zero when all are zero
  function automatic logic [POS_W-1:0] lead_pos(input logic [DIGITS-1:0][3:0] bcd);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i] != 4'd0) begin
        p = POS_W'(i);
      end
    end
    return p;
  endfunction

endpackage

// ===== rtl/core/sbda_value_if.sv =====
interface sbda_value_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// ===== rtl/core/sbda_char_if.sv =====
interface sbda_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

// ===== rtl/core/signed_binary_to_decimal_ascii.sv =====
// Signed binary to decimal ASCII. Each transaction on num carries one signed
// 32-bit value; the block answers with its decimal text on text, one ASCII
// character per transaction, most significant first: a leading '-' for
// negative values, no leading zeros, a single '0' for zero, and last set on
// the final character. The full range including -2147483648 is rendered.
// An input passes the entry register and four double dabble stages of
// eight steps each, then the character serializer, which sends one
// character per cycle while text is ready; a value is rendered as 1 to 11
// characters, and the pipeline keeps accepting values until that serializer
// backs it up.
module signed_binary_to_decimal_ascii import sbda_pkg::*; (
  input logic          clk,
  input logic          rst,
  sbda_value_if.sink   num,
  sbda_char_if.source  text
);

  // Entry register: sign and magnitude
  logic    ent_vld;
  dabble_t ent_data;
  logic    ent_ready;

  logic    [DABBLE_STAGES:0] stg_valid;
  logic    [DABBLE_STAGES:0] stg_ready;
  dabble_t                   stg_data [DABBLE_STAGES+1];

  assign ent_ready = !ent_vld || stg_ready[0];
  assign num.ready = ent_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= 1'b0;
    end else if (ent_ready) begin
      ent_vld <= num.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_ready && num.valid) begin
      ent_data.neg <= num.value[VALUE_W-1];
      ent_data.bin <= num.value[VALUE_W-1] ? (~num.value + 32'd1) : num.value;
      ent_data.bcd <= '0;
    end
  end

  assign stg_valid[0] = ent_vld;
  assign stg_data[0]  = ent_data;

  // Double dabble pipeline
  for (genvar k = 0; k < DABBLE_STAGES; k++) begin : g_stage
    sbda_dabble u_dabble (
      .clk      (clk),
      .rst      (rst),
      .up_valid (stg_valid[k]),
      .up_ready (stg_ready[k]),
      .up_data  (stg_data[k]),
      .dn_valid (stg_valid[k+1]),
      .dn_ready (stg_ready[k+1]),
      .dn_data  (stg_data[k+1])
    );
  end

  // Character serializer
  logic                   busy;
  logic                   minus_pend;
  logic [POS_W-1:0]       pos;
  logic [DIGITS-1:0][3:0] bcd;
  logic                   out_take;
  logic                   done;
  logic                   load;

  assign out_take = text.valid && text.ready;
  assign done     = out_take && text.last;
  assign stg_ready[DABBLE_STAGES] = !busy || done;
  assign load     = stg_ready[DABBLE_STAGES] && stg_valid[DABBLE_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      minus_pend <= 1'b0;
      pos        <= '0;
    end else if (load) begin
      busy       <= 1'b1;
      minus_pend <= stg_data[DABBLE_STAGES].neg;
      pos        <= lead_pos(stg_data[DABBLE_STAGES].bcd);
    end else if (done) begin
      busy <= 1'b0;
    end else if (out_take) begin
      // step past the sign, then down through the digits
      if (minus_pend) begin
        minus_pend <= 1'b0;
      end else begin
        pos <= pos - POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bcd <= stg_data[DABBLE_STAGES].bcd;
    end
  end

  assign text.valid     = busy;
  assign text.character = minus_pend ? CHAR_MINUS : (CHAR_ZERO + {4'd0, bcd[pos]});
  assign text.last      = !minus_pend && (pos == '0);

  // A finished number with nothing queued behind it leaves the output idle
  assert property (@(posedge clk) disable iff (rst)
    (done && !stg_valid[DABBLE_STAGES]) |=> !text.valid)
    else $error("serializer stayed busy after last character");

  // Digit position never leaves the ten-digit range
  assert property (@(posedge clk) disable iff (rst)
    busy |-> (pos < POS_W'(DIGITS)))
    else $error("digit position out of range");

  // Every character sent is a sign or a decimal digit
  assert property (@(posedge clk) disable iff (rst)
    text.valid |-> (text.character == CHAR_MINUS ||
                    (text.character >= CHAR_ZERO && text.character <= CHAR_ZERO + 8'd9)))
    else $error("character is not a sign or a digit");

  // The sign is never the final character
  assert property (@(posedge clk) disable iff (rst)
    (text.valid && minus_pend) |-> !text.last)
    else $error("sign marked as last character");

endmodule

// ===== rtl/core/sbda_dabble.sv =====
module sbda_dabble import sbda_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    up_valid,
  output logic    up_ready,
  input  dabble_t up_data,
  output logic    dn_valid,
  input  logic    dn_ready,
  output dabble_t dn_data
);

  logic    vld;
  dabble_t data;

  // Take a new transaction when empty or when the downstream takes ours
  assign up_ready = !vld || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  // Advance the conversion by one stage worth of steps
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= dabble_stage(up_data);
    end
  end

  assign dn_valid = vld;
  assign dn_data  = data;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import sbda_pkg::*;

  localparam int HOLD_OFF_START = 600;
  localparam int HOLD_OFF_LEN   = 300;
  localparam int IDLE_LIMIT     = 5000;
  localparam int RANDOM_ITEMS   = 405;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_PRINTED    = 100;

  // One character of rendered text, tagged with the number it came from
  typedef struct {
    logic [CHAR_W-1:0]  character;
    logic               last;
    logic [VALUE_W-1:0] source;
  } text_char_t;

  logic clk;
  logic rst;

  sbda_value_if num_if();
  sbda_char_if  text_if();

  signed_binary_to_decimal_ascii u_top (
    .clk  (clk),
    .rst  (rst),
    .num  (num_if),
    .text (text_if)
  );

  logic signed [VALUE_W-1:0] pending_values[$];
  text_char_t                expected_chars[$];
  int                        mismatch_count;
  int                        idle_cycles;
  int                        burst_left;
  int                        gap_left;
  int                        rx_cycle;
  bit                        value_taken;

  always #4 clk = ~clk;

  // Render a value as decimal text and queue the characters it should produce
  function automatic void append_decimal_text(input logic [VALUE_W-1:0] v);
    logic [VALUE_W:0] mag;
    logic [3:0]       digit_buf[DIGITS];
    int               ndigits;
    text_char_t       c;
    ndigits = 0;
    mag = v[VALUE_W-1] ? ((33'h1_0000_0000 - {1'b0, v}) & 33'h1_FFFF_FFFF) : {1'b0, v};
    do begin
      digit_buf[ndigits] = 4'(mag % 10);
      ndigits++;
      mag = mag / 10;
    end while (mag != 0);
    c.source = v;
    if (v[VALUE_W-1]) begin
      c.character = CHAR_MINUS;
      c.last = 1'b0;
      expected_chars.push_back(c);
    end
    for (int i = ndigits - 1; i >= 0; i--) begin
      c.character = CHAR_ZERO + CHAR_W'(digit_buf[i]);
      c.last = (i == 0);
      expected_chars.push_back(c);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // Pick a random value: fully random, an edge case, or one whose magnitude has a random number of digits
  function automatic logic [VALUE_W-1:0] random_value();
    int unsigned lim;
    int unsigned mag;
    int          sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      return $urandom;
    end
    if (sel == 3) begin
      // land on or next to a power of ten, on a range limit, or on zero
      case ($urandom_range(0, 4))
        0: mag = 1;
        1: mag = 10 ** $urandom_range(0, 9);
        2: mag = 10 ** $urandom_range(1, 9) - 1;
        3: mag = 32'h7FFF_FFFF;
        default: mag = 0;
      endcase
    end else begin
      lim = 10 ** $urandom_range(1, 9) - 1;
      mag = $urandom_range(lim, 0);
    end
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // Offer pending values in bursts; hold each one until its transaction completes
  always @(negedge clk) begin
    if (rst) begin
      num_if.valid = 1'b0;
    end else if (num_if.valid && !value_taken) begin
      num_if.valid = 1'b1;
    end else begin
      value_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        num_if.valid = 1'b0;
      end else if (pending_values.size() != 0) begin
        num_if.valid = 1'b1;
        num_if.value = pending_values[0];
        burst_left--;
        if (burst_left <= 0) begin
          gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
          burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
        end
      end else begin
        num_if.valid = 1'b0;
      end
    end
  end

  // Stall the text side: a long hold-off early on, then rotating patterns
  always @(negedge clk) begin
    if (rst) begin
      text_if.ready = 1'b0;
      rx_cycle = 0;
    end else begin
      rx_cycle++;
      if (rx_cycle >= HOLD_OFF_START && rx_cycle < HOLD_OFF_START + HOLD_OFF_LEN) begin
        text_if.ready = 1'b0;
      end else begin
        case ((rx_cycle / 256) % 4)
          0: text_if.ready = 1'b1;
          1: text_if.ready = $urandom_range(0, 1);
          2: text_if.ready = ($urandom_range(0, 7) != 0);
          default: text_if.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Predict on input transactions, check output transactions, watch for a hang
  always @(posedge clk) begin
    text_char_t exp_c;
    bit         moved;
    moved = 1'b0;
    if (!rst) begin
      if (num_if.valid && num_if.ready) begin
        append_decimal_text(num_if.value);
        void'(pending_values.pop_front());
        value_taken = 1'b1;
        moved = 1'b1;
      end
      if (text_if.valid && text_if.ready) begin
        moved = 1'b1;
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character %0d last %0b",
                                    text_if.character, text_if.last));
        end else begin
          exp_c = expected_chars.pop_front();
          if (text_if.character !== exp_c.character) begin
            report_mismatch($sformatf("value %0d: character %0d, expected %0d",
                                      $signed(exp_c.source), text_if.character,
                                      exp_c.character));
          end
          if (text_if.last !== exp_c.last) begin
            report_mismatch($sformatf("value %0d: last %0b, expected %0b",
                                      $signed(exp_c.source), text_if.last, exp_c.last));
          end
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    num_if.valid = 1'b0;
    num_if.value = '0;
    text_if.ready = 1'b0;
    mismatch_count = 0;
    idle_cycles = 0;
    burst_left = 1;
    gap_left = 0;
    rx_cycle = 0;
    value_taken = 1'b0;

    // Directed: zero, sign and range limits, text lengths 1, 2, 3, 5, 7, 9, 10 and 11
    pending_values.push_back(0);
    pending_values.push_back(1);
    pending_values.push_back(-1);
    pending_values.push_back(9);
    pending_values.push_back(-9);
    pending_values.push_back(10);
    pending_values.push_back(-10);
    pending_values.push_back(100);
    pending_values.push_back(-4096);
    pending_values.push_back(99999);
    pending_values.push_back(-100000);
    pending_values.push_back(1234567);
    pending_values.push_back(-98765432);
    pending_values.push_back(999999999);
    pending_values.push_back(-999999999);
    pending_values.push_back(1000000000);
    pending_values.push_back(-1000000000);
    pending_values.push_back(1234567890);
    pending_values.push_back(-1234567890);
    pending_values.push_back(32'sh7FFF_FFFF);
    pending_values.push_back(32'sh8000_0000);
    pending_values.push_back(32'sh8000_0001);
    pending_values.push_back(32'sh5555_5555);
    pending_values.push_back(32'shAAAA_AAAA);
    pending_values.push_back(0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pending_values.push_back(random_value());
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Drain: every value taken, every character seen, then a short settle
    while (pending_values.size() != 0 || expected_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sbda_pkg.sv
rtl/core/sbda_value_if.sv
rtl/core/sbda_char_if.sv
rtl/core/sbda_dabble.sv
rtl/core/signed_binary_to_decimal_ascii.sv
bench/testbench.sv
